FILE: rtl/mmc_pkg.sv
package mmc_pkg;

  // Field sizes
  localparam int unsigned NUM_MAPS     = 8;
  localparam int unsigned MAX_MAPS     = 8;
  localparam int unsigned HEIGHT_WIDTH = 24;
  localparam int unsigned COUNT_WIDTH  = 4;

  // Sorting network size and depth (odd-even merge sort of eight keys)
  localparam int unsigned SORT_N      = 8;
  localparam int unsigned SORT_LAYERS = 6;
  localparam int unsigned IDX_W       = $clog2(SORT_N);

  // Stream and register port widths
  localparam int unsigned IN_TDATA_W  = ((MAX_MAPS * HEIGHT_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((HEIGHT_WIDTH + COUNT_WIDTH + 7) / 8) * 8;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  // Register index
  localparam logic [APB_AW-3:0] REG_INVALID_MARKER = '0;

  localparam logic signed [HEIGHT_WIDTH-1:0] MARKER_RESET = -HEIGHT_WIDTH'(256);

  typedef logic signed [HEIGHT_WIDTH-1:0] height_t;
  typedef logic [COUNT_WIDTH-1:0]         count_t;

  // Sort key: dropped heights carry inv and sort above every valid one
  typedef struct packed {
    logic    inv;
    height_t val;
  } key_t;

  typedef key_t [SORT_N-1:0] key_arr_t;

  // Payload that moves between pipeline stages
  typedef struct packed {
    key_arr_t keys;
    count_t   cnt;
  } stage_t;

  function automatic logic key_gt(input key_t a, input key_t b);
    logic gt;
    if (a.inv != b.inv) begin
      gt = a.inv;
    end else if (a.inv) begin
      gt = 1'b0;
    end else begin
      gt = (a.val > b.val);
    end
    return gt;
  endfunction

  // One compare-exchange element
  function automatic key_arr_t cx(input key_arr_t a, input int lo, input int hi);
    key_arr_t r;
    r = a;
    if (key_gt(a[lo], a[hi])) begin
      r[lo] = a[hi];
      r[hi] = a[lo];
    end
    return r;
  endfunction

  // One layer of independent compare-exchange elements
  function automatic key_arr_t sort_layer(input key_arr_t a, input int layer);
    key_arr_t r;
    r = a;
    case (layer)
      0: begin
        r = cx(r, 0, 1); r = cx(r, 2, 3); r = cx(r, 4, 5); r = cx(r, 6, 7);
      end
      1: begin
        r = cx(r, 0, 2); r = cx(r, 1, 3); r = cx(r, 4, 6); r = cx(r, 5, 7);
      end
      2: begin
        r = cx(r, 1, 2); r = cx(r, 5, 6);
      end
      3: begin
        r = cx(r, 0, 4); r = cx(r, 1, 5); r = cx(r, 2, 6); r = cx(r, 3, 7);
      end
      4: begin
        r = cx(r, 2, 4); r = cx(r, 3, 5);
      end
      5: begin
        r = cx(r, 1, 2); r = cx(r, 3, 4); r = cx(r, 5, 6);
      end
      default: begin
        r = a;
      end
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/mmc_mask.sv
module mmc_mask
  import mmc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_TDATA_W-1:0] data_i,
  input  height_t               marker_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  output stage_t                stage_o,
  output logic                  valid_o,
  input  logic                  ready_i
);

  logic   vld_q;
  stage_t stage_q, stage_d;

  // Tag dropped heights and count the rest
  always_comb begin
    count_t cnt;
    cnt = '0;
    for (int k = 0; k < SORT_N; k++) begin
      if (k < MAX_MAPS) begin
        stage_d.keys[k].val = data_i[k*HEIGHT_WIDTH +: HEIGHT_WIDTH];
      end else begin
        stage_d.keys[k].val = '0;
      end
      stage_d.keys[k].inv = (k >= NUM_MAPS) || (stage_d.keys[k].val == marker_i);
      cnt = cnt + COUNT_WIDTH'(!stage_d.keys[k].inv);
    end
    stage_d.cnt = cnt;
  end

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign stage_o = stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q <= stage_d;
    end
  end

endmodule

FILE: rtl/mmc_sort_lo.sv
module mmc_sort_lo
  import mmc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  stage_t stage_i,
  input  logic   valid_i,
  output logic   ready_o,
  output stage_t stage_o,
  output logic   valid_o,
  input  logic   ready_i
);

  logic   vld_q;
  stage_t stage_q, stage_d;

  // First half of the network: pairs sorted, then merged into sorted quads
  always_comb begin
    key_arr_t k;
    k = stage_i.keys;
    for (int l = 0; l < SORT_LAYERS / 2; l++) begin
      k = sort_layer(k, l);
    end
    stage_d.keys = k;
    stage_d.cnt  = stage_i.cnt;
  end

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign stage_o = stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q <= stage_d;
    end
  end

endmodule

FILE: rtl/mmc_sort_hi.sv
module mmc_sort_hi
  import mmc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  stage_t stage_i,
  input  logic   valid_i,
  output logic   ready_o,
  output stage_t stage_o,
  output logic   valid_o,
  input  logic   ready_i
);

  logic   vld_q;
  stage_t stage_q, stage_d;

  // Second half of the network: final merge of the two quads
  always_comb begin
    key_arr_t k;
    k = stage_i.keys;
    for (int l = SORT_LAYERS / 2; l < SORT_LAYERS; l++) begin
      k = sort_layer(k, l);
    end
    stage_d.keys = k;
    stage_d.cnt  = stage_i.cnt;
  end

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign stage_o = stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q <= stage_d;
    end
  end

endmodule

FILE: rtl/mmc_select.sv
module mmc_select
  import mmc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  stage_t  stage_i,
  input  logic    valid_i,
  output logic    ready_o,
  output height_t median_o,
  output count_t  count_o,
  output logic    valid_o,
  input  logic    ready_i
);

  logic    vld_q;
  height_t median_q, median_d;
  count_t  count_q;

  // Pick the middle pair; for an odd count both picks are the same key
  always_comb begin
    count_t                        n_m1;
    logic [IDX_W-1:0]              lo_idx;
    logic [IDX_W-1:0]              hi_idx;
    logic signed [HEIGHT_WIDTH:0]  sum;
    n_m1   = stage_i.cnt - COUNT_WIDTH'(1);
    lo_idx = IDX_W'(n_m1 >> 1);
    hi_idx = IDX_W'(stage_i.cnt >> 1);
    sum    = (HEIGHT_WIDTH+1)'(stage_i.keys[lo_idx].val)
           + (HEIGHT_WIDTH+1)'(stage_i.keys[hi_idx].val);
    if (stage_i.cnt == '0) begin
      median_d = '0;
    end else begin
      // arithmetic halving rounds toward minus infinity
      median_d = sum[HEIGHT_WIDTH:1];
    end
  end

  assign ready_o  = !vld_q || ready_i;
  assign valid_o  = vld_q;
  assign median_o = median_q;
  assign count_o  = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      median_q <= median_d;
      count_q  <= stage_i.cnt;
    end
  end

endmodule

FILE: rtl/masked_median_combine.sv
// Masked median of eight co-registered height maps, one pixel per item.
// Input stream (s_axis): one pixel's eight heights per item; valid/ready
// handshake. Output stream (m_axis): median height and valid count.
// Heights equal to the invalid_marker register are left out; an even count
// gives the floor of the mean of the middle pair, no valid height gives 0.
// Register port: APB-style, invalid_marker at byte address 0, pready tied
// high; write only while no item is in flight.
// Four register stages: marker test and count, two halves of a 6-layer
// odd-even merge sorting network, then middle select and average into the
// output register. Throughput: one item per cycle while the output is not
// stalled. Each stage loads whenever it is empty or its successor loads, so
// bubbles collapse under backpressure.
// Reset clears all stage valid bits and sets invalid_marker to -1.0 (-256).
// When the receiver stalls the output holds; upstream stages keep filling,
// and s_axis_tready drops only once all four stages hold items.
module masked_median_combine
  import mmc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // APB-style register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready,
  // input stream, tdata: height_0 .. height_7 from bit 0 up
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // output stream, tdata: median_height, valid_count, zero pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  height_t marker_q;
  stage_t  mask_stage, lo_stage, hi_stage;
  logic    mask_vld, lo_vld, hi_vld;
  logic    mask_rdy, lo_rdy, hi_rdy;
  height_t median;
  count_t  count;
  logic    reg_wr;

  // Register port
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready
                  && (paddr[APB_AW-1:2] == REG_INVALID_MARKER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= MARKER_RESET;
    end else if (reg_wr) begin
      marker_q <= pwdata[HEIGHT_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1:2] == REG_INVALID_MARKER) begin
      prdata = APB_DW'(marker_q);
    end
  end

  // Pipeline
  mmc_mask u_mask (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .data_i   (s_axis_tdata),
    .marker_i (marker_q),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .stage_o  (mask_stage),
    .valid_o  (mask_vld),
    .ready_i  (mask_rdy)
  );

  mmc_sort_lo u_sort_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (mask_stage),
    .valid_i (mask_vld),
    .ready_o (mask_rdy),
    .stage_o (lo_stage),
    .valid_o (lo_vld),
    .ready_i (lo_rdy)
  );

  mmc_sort_hi u_sort_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (lo_stage),
    .valid_i (lo_vld),
    .ready_o (lo_rdy),
    .stage_o (hi_stage),
    .valid_o (hi_vld),
    .ready_i (hi_rdy)
  );

  mmc_select u_select (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (hi_stage),
    .valid_i  (hi_vld),
    .ready_o  (hi_rdy),
    .median_o (median),
    .count_o  (count),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = OUT_TDATA_W'({count, median});

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (count <= COUNT_WIDTH'(NUM_MAPS)))
    else $error("valid count above number of maps");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && count == '0) |-> (median == '0))
    else $error("nonzero median with no valid height");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && mask_vld && lo_vld && hi_vld))
    else $error("input stalled without a full pipe and output backpressure");

endmodule
